/* design/wsd_pkg.sv */
// Package for the WebSocket frame deframer.
// Holds parse phase codes, opcodes, event codes and the event record type.
// No dependencies.
`default_nettype none

package wsd_pkg;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CLOSED  = 3'd5;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	localparam logic [2:0] EV_BYTE     = 3'd0;
	localparam logic [2:0] EV_EMPTY    = 3'd1;
	localparam logic [2:0] EV_CLOSE    = 3'd2;
	localparam logic [2:0] EV_PONG     = 3'd3;
	localparam logic [2:0] EV_OVERSIZE = 3'd4;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd10485760;

	typedef struct packed {
		logic       valid;
		logic [2:0] kind;
		logic [3:0] opcode;
		logic [7:0] value;
		logic       last;
	} wsd_event_t;

endpackage

`default_nettype wire

/* design/wsd_parser.sv */
// Frame parser: header, length, mask key and payload unmasking for one byte per cycle while accept is high.
// Produces at most one event record per accepted byte. Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic [31:0]       max_len,
	output wsd_pkg::wsd_event_t    result
);
	import wsd_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;

	logic        len_known;
	logic [63:0] len_val;
	logic        hdr_known;
	logic [63:0] hdr_len;
	logic        frame_end;
	logic        frame_empty;
	logic        is_data;
	logic [3:0]  cnt_dec;
	logic [63:0] len_dec;
	logic [7:0]  key_byte;
	logic        last;
	wsd_event_t  ev;

	always_comb begin
		unique case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign is_data = (opcode_q == OP_TEXT) || (opcode_q == OP_BINARY);
	assign cnt_dec = cnt_q - 4'd1;
	assign len_dec = len_q - 64'd1;
	assign last    = (len_q == 64'd1);

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		opcode_d    = opcode_q;
		mask_d      = mask_q;
		len_d       = len_q;
		key_d       = key_q;
		idx_d       = idx_q;
		len_known   = 1'b0;
		len_val     = len_q;
		hdr_known   = 1'b0;
		hdr_len     = len_q;
		frame_end   = 1'b0;
		frame_empty = 1'b0;
		ev          = '0;
		ev.opcode   = opcode_q;

		unique case (phase_q)
			PH_HDR0: begin
				opcode_d = data_byte[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = data_byte[7];
				if (data_byte[6:0] == LEN7_EXT16 || data_byte[6:0] == LEN7_EXT64) begin
					cnt_d   = (data_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					len_d   = '0;
					phase_d = PH_EXTLEN;
				end else begin
					len_known = 1'b1;
					len_val   = {57'd0, data_byte[6:0]};
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[55:0], data_byte};
				cnt_d = cnt_dec;
				if (cnt_dec == 4'd0) begin
					len_known = 1'b1;
					len_val   = {len_q[55:0], data_byte};
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], data_byte};
				cnt_d = cnt_dec;
				if (cnt_dec == 4'd0) begin
					hdr_known = 1'b1;
					hdr_len   = len_q;
				end
			end
			PH_PAYLOAD: begin
				idx_d = idx_q + 2'd1;
				len_d = len_dec;
				if (is_data) begin
					ev.valid = 1'b1;
					ev.kind  = EV_BYTE;
					ev.value = data_byte ^ (mask_q ? key_byte : 8'h00);
					ev.last  = last;
					if (last) begin
						phase_d = PH_HDR0;
					end
				end else if (last) begin
					frame_end = 1'b1;
				end
			end
			default: begin
				phase_d = PH_CLOSED;
			end
		endcase

		if (len_known) begin
			len_d = len_val;
			if (len_val > {32'd0, max_len}) begin
				phase_d  = PH_CLOSED;
				ev.valid = 1'b1;
				ev.kind  = EV_OVERSIZE;
			end else if (mask_d) begin
				key_d   = '0;
				cnt_d   = KEY_BYTES;
				phase_d = PH_MASK;
			end else begin
				hdr_known = 1'b1;
				hdr_len   = len_val;
			end
		end

		if (hdr_known) begin
			idx_d = '0;
			if (hdr_len == 64'd0) begin
				frame_end   = 1'b1;
				frame_empty = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		if (frame_end) begin
			phase_d = PH_HDR0;
			priority if (opcode_q == OP_CLOSE) begin
				phase_d  = PH_CLOSED;
				ev.valid = 1'b1;
				ev.kind  = EV_CLOSE;
			end else if (opcode_q == OP_PING) begin
				ev.valid = 1'b1;
				ev.kind  = EV_PONG;
			end else if (frame_empty && is_data) begin
				ev.valid = 1'b1;
				ev.kind  = EV_EMPTY;
				ev.last  = 1'b1;
			end
		end
	end

	always_comb begin
		result       = ev;
		result.valid = ev.valid & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			cnt_q    <= '0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
		end
	end

endmodule

`default_nettype wire

/* design/wsd_out_buf.sv */
// Two-entry event output buffer: result register plus skid register.
// Lets the parser keep taking bytes while an event waits. Depends on wsd_pkg.
`default_nettype none

module wsd_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wsd_pkg::wsd_event_t result,
	output logic                   full,
	output logic                   event_valid,
	input  wire logic              event_stall,
	output wsd_pkg::wsd_event_t    event_rec
);
	import wsd_pkg::*;

	wsd_event_t out_q;
	wsd_event_t skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       take;

	assign take        = out_valid_q && !event_stall;
	assign full        = skid_valid_q;
	assign event_valid = out_valid_q;
	assign event_rec   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (result.valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (result.valid) begin
			if (!out_valid_q || take) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

endmodule

`default_nettype wire

/* design/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: configuration register, parser and output buffer.
// Depends on wsd_pkg, wsd_parser and wsd_out_buf.
`default_nettype none

// The deframer takes one received stream byte per cycle and gives at most one event per
// byte; the event is registered in the output buffer before it reaches the outputs. Input
// bytes keep flowing at one per cycle as long as events are taken; a two-entry output
// buffer absorbs a stalled event, and data_stall rises only when both entries are full.
// After a close event or an oversize error, bytes are accepted and dropped until reset.
// The length limit may be rewritten through the configuration channel, which is always ready.
module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] max_payload_length,
	output logic             event_valid,
	input  wire logic        event_stall,
	output logic [2:0]       event_kind,
	output logic [3:0]       frame_opcode,
	output logic [7:0]       payload_value,
	output logic             last_of_message
);
	import wsd_pkg::*;

	logic [31:0] max_len_q;
	logic        accept;
	logic        full;
	wsd_event_t  result;
	wsd_event_t  event_rec;

	assign cfg_ready  = 1'b1;
	assign data_stall = full;
	assign accept     = data_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_payload_length;
		end
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.max_len   (max_len_q),
		.result    (result)
	);

	wsd_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.result      (result),
		.full        (full),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_rec   (event_rec)
	);

	assign event_kind      = event_rec.kind;
	assign frame_opcode    = event_rec.opcode;
	assign payload_value   = event_rec.value;
	assign last_of_message = event_rec.last;

endmodule

`default_nettype wire
